>>> src/jkv_pkg.sv
`timescale 1ns / 1ps
// jkv_pkg: shared types, character codes and helpers for the json key/value extractor
// no dependencies

package jkv_pkg;

    localparam int KEY_MAX_DEF  = 16;
    localparam int TEXT_MAX_DEF = 65536;

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int KEY_LEN_W = 5;
    localparam int POS_W     = 16;
    localparam int LEN_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;

    typedef enum logic [7:0] {
        PH_SEARCH = 8'b0000_0001,
        PH_WS1    = 8'b0000_0010,
        PH_COLON  = 8'b0000_0100,
        PH_WS2    = 8'b0000_1000,
        PH_OBJECT = 8'b0001_0000,
        PH_ARRAY  = 8'b0010_0000,
        PH_STRING = 8'b0100_0000,
        PH_OTHER  = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctrl;

    function automatic logic is_ws(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    endfunction

    function automatic logic is_value_end(input logic [7:0] c);
        return c inside {CH_SPACE, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                         CH_COMMA, CH_LF, CH_CR};
    endfunction

endpackage

>>> src/jkv_key_window.sv
`timescale 1ns / 1ps
// jkv_key_window: history of recent text bytes and the quoted-key window compare
// depends on jkv_pkg

module jkv_key_window #(
    parameter int KEY_MAX = jkv_pkg::KEY_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  jkv_pkg::t_win_ctrl            i_ctrl,
    input  logic [7:0]                    i_byte,
    input  logic [2*jkv_pkg::CFG_W-1:0]   i_key,
    input  logic [jkv_pkg::KEY_LEN_W-1:0] i_key_len,
    output logic                          o_match
);

    localparam int HIST = KEY_MAX + 1;
    localparam int LW   = $clog2(KEY_MAX + 1);

    logic [7:0]    r_hist [HIST];
    logic [7:0]    n_win  [HIST+1];
    logic [LW-1:0] eff_len;
    logic [KEY_MAX:0] len_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            for (int k = 0; k < HIST; k++) begin
                r_hist[k] <= 8'h00;
            end
        end else if (i_ctrl.shift) begin
            for (int k = 0; k < HIST; k++) begin
                r_hist[k] <= n_win[k];
            end
        end
    end

    // window as it stands once the current byte is shifted in
    always_comb begin
        n_win[0] = i_byte;
        for (int k = 1; k <= HIST; k++) begin
            n_win[k] = r_hist[k-1];
        end
    end

    always_comb begin
        if (i_key_len > jkv_pkg::KEY_LEN_W'(KEY_MAX)) begin
            eff_len = LW'(KEY_MAX);
        end else begin
            eff_len = i_key_len[LW-1:0];
        end
    end

    // one candidate per key length, picked by the configured length
    always_comb begin
        for (int l = 0; l <= KEY_MAX; l++) begin
            len_match[l] = (n_win[0] == jkv_pkg::CH_QUOTE) &&
                           (n_win[l+1] == jkv_pkg::CH_QUOTE);
            for (int i = 0; i < KEY_MAX; i++) begin
                if (i < l) begin
                    len_match[l] = len_match[l] && (n_win[l-i] == i_key[8*i +: 8]);
                end
            end
        end
    end

    assign o_match = len_match[eff_len];

endmodule

>>> src/json_key_value_extractor_unit.sv
`timescale 1ns / 1ps
// json_key_value_extractor_unit: top level, scan state machine, value measure, output queue
// depends on jkv_pkg and jkv_key_window

// Takes one JSON text byte per clock cycle with no gaps needed while o_in_stall is low: every byte is
// handled in the cycle it is accepted by the key window compare and the scan
// state update, so back-to-back bytes run at full rate. A result (found with
// value offset and length, or not found on the end-of-text byte) is registered
// into the output entry, or into the skid entry behind a held output; a
// two-entry output queue lets input continue while one result waits, and input
// stalls only when both entries are full. The user must write key registers
// through the config port only while no text is in flight; the block does not enforce it.

module json_key_value_extractor_unit #(
    parameter int KEY_MAX  = jkv_pkg::KEY_MAX_DEF,
    parameter int TEXT_MAX = jkv_pkg::TEXT_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [jkv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [jkv_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_text_byte,
    input  logic                          i_end_of_text,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [jkv_pkg::POS_W-1:0]     o_value_offset,
    output logic [jkv_pkg::LEN_W-1:0]     o_value_length
);

    localparam int PW = jkv_pkg::POS_W;
    localparam int LW = jkv_pkg::LEN_W;
    localparam logic [PW:0] POS_LAST = (PW + 1)'(TEXT_MAX - 1);

    // config registers
    logic [jkv_pkg::CFG_W-1:0]     r_key_low;
    logic [jkv_pkg::CFG_W-1:0]     r_key_high;
    logic [jkv_pkg::KEY_LEN_W-1:0] r_key_len;

    // scan state
    jkv_pkg::t_phase r_phase, n_phase;
    logic            r_done, n_done;
    logic [PW-1:0]   r_depth, n_depth;
    logic [PW-1:0]   r_pos, n_pos;
    logic [PW-1:0]   r_start, n_start;

    // output queue
    logic          r_out_valid;
    logic          r_out_found;
    logic [PW-1:0] r_out_offset;
    logic [LW-1:0] r_out_length;
    logic          r_skid_valid;
    logic          r_skid_found;
    logic [PW-1:0] r_skid_offset;
    logic [LW-1:0] r_skid_length;

    logic               in_fire;
    logic               out_fire;
    logic               key_match;
    jkv_pkg::t_win_ctrl win_ctrl;

    logic          emit;
    logic          begin_v;
    logic [PW-1:0] emit_off;
    logic [PW:0]   emit_end;
    logic [PW:0]   pos_inc;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] depth_dec;
    logic [7:0]    open_c;
    logic [7:0]    close_c;
    logic [PW:0]   len_diff;

    logic          res_valid;
    logic          res_found;
    logic [PW-1:0] res_offset;
    logic [LW-1:0] res_length;

    assign in_fire    = i_in_valid && !o_in_stall;
    assign out_fire   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                jkv_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                jkv_pkg::REG_KEY_HIGH: r_key_high <= i_cfg_data;
                jkv_pkg::REG_KEY_LEN:  r_key_len  <= i_cfg_data[jkv_pkg::KEY_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    jkv_key_window #(
        .KEY_MAX (KEY_MAX)
    ) u_key_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (win_ctrl),
        .i_byte    (i_text_byte),
        .i_key     ({r_key_high, r_key_low}),
        .i_key_len (r_key_len),
        .o_match   (key_match)
    );

    always_comb begin
        pos_inc = {1'b0, r_pos} + (PW + 1)'(1);
        if (pos_inc > POS_LAST) begin
            pos_next = POS_LAST[PW-1:0];
        end else begin
            pos_next = pos_inc[PW-1:0];
        end
        depth_dec = (r_depth != '0) ? r_depth - PW'(1) : '0;
        if (r_phase == jkv_pkg::PH_ARRAY) begin
            open_c  = jkv_pkg::CH_LBRACK;
            close_c = jkv_pkg::CH_RBRACK;
        end else begin
            open_c  = jkv_pkg::CH_LBRACE;
            close_c = jkv_pkg::CH_RBRACE;
        end
    end

    // next scan state for the byte at the input
    always_comb begin
        n_phase  = r_phase;
        n_done   = r_done;
        n_depth  = r_depth;
        n_pos    = pos_next;
        n_start  = r_start;
        emit     = 1'b0;
        begin_v  = 1'b0;
        emit_off = r_start;
        emit_end = {1'b0, r_pos};
        win_ctrl = '0;

        if (!r_done) begin
            case (r_phase)
                jkv_pkg::PH_SEARCH: begin
                    win_ctrl.shift = in_fire;
                    if (key_match) begin
                        n_phase = jkv_pkg::PH_WS1;
                    end
                end
                jkv_pkg::PH_WS1: begin
                    if (!jkv_pkg::is_ws(i_text_byte)) begin
                        if (i_text_byte == jkv_pkg::CH_COLON) begin
                            n_phase = jkv_pkg::PH_COLON;
                        end else begin
                            begin_v = 1'b1;
                        end
                    end
                end
                jkv_pkg::PH_COLON: begin
                    if (i_text_byte != jkv_pkg::CH_COLON) begin
                        if (jkv_pkg::is_ws(i_text_byte)) begin
                            n_phase = jkv_pkg::PH_WS2;
                        end else begin
                            begin_v = 1'b1;
                        end
                    end
                end
                jkv_pkg::PH_WS2: begin
                    begin_v = !jkv_pkg::is_ws(i_text_byte);
                end
                jkv_pkg::PH_OBJECT, jkv_pkg::PH_ARRAY: begin
                    if (i_text_byte == close_c) begin
                        n_depth = depth_dec;
                        if (depth_dec == '0) begin
                            emit     = 1'b1;
                            emit_end = pos_inc;
                        end
                    end else if (i_text_byte == open_c && r_depth != '1) begin
                        n_depth = r_depth + PW'(1);
                    end
                end
                jkv_pkg::PH_STRING: begin
                    emit = (i_text_byte == jkv_pkg::CH_QUOTE);
                end
                default: begin
                    emit = jkv_pkg::is_value_end(i_text_byte);
                end
            endcase

            if (begin_v) begin
                if (i_text_byte == jkv_pkg::CH_LBRACE || i_text_byte == jkv_pkg::CH_LBRACK) begin
                    n_start = r_pos;
                    n_depth = PW'(1);
                    n_phase = (i_text_byte == jkv_pkg::CH_LBRACE) ? jkv_pkg::PH_OBJECT
                                                                  : jkv_pkg::PH_ARRAY;
                end else if (i_text_byte == jkv_pkg::CH_QUOTE) begin
                    n_start = pos_next;
                    n_phase = jkv_pkg::PH_STRING;
                end else if (jkv_pkg::is_value_end(i_text_byte)) begin
                    emit     = 1'b1;
                    emit_off = r_pos;
                    emit_end = {1'b0, r_pos};
                end else begin
                    n_start = r_pos;
                    n_phase = jkv_pkg::PH_OTHER;
                end
            end

            if (emit) begin
                n_done  = 1'b1;
                n_phase = jkv_pkg::PH_SEARCH;
            end
        end

        if (i_end_of_text) begin
            n_phase        = jkv_pkg::PH_SEARCH;
            n_done         = 1'b0;
            n_depth        = '0;
            n_pos          = '0;
            n_start        = '0;
            win_ctrl.clear = in_fire;
        end
    end

    // result of the byte at the input
    always_comb begin
        len_diff = (emit_end > {1'b0, emit_off}) ? emit_end - {1'b0, emit_off} : '0;
        res_valid = in_fire && (emit || (i_end_of_text && !r_done));
        res_found = emit;
        if (emit) begin
            res_offset = emit_off;
            res_length = len_diff[PW] ? '1 : len_diff[LW-1:0];
        end else begin
            res_offset = '0;
            res_length = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jkv_pkg::PH_SEARCH;
            r_done  <= 1'b0;
            r_depth <= '0;
            r_pos   <= '0;
            r_start <= '0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_done  <= n_done;
            r_depth <= n_depth;
            r_pos   <= n_pos;
            r_start <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_found  <= r_skid_found;
                r_out_offset <= r_skid_offset;
                r_out_length <= r_skid_length;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid  <= 1'b1;
                r_out_found  <= res_found;
                r_out_offset <= res_offset;
                r_out_length <= res_length;
            end else begin
                r_skid_valid  <= 1'b1;
                r_skid_found  <= res_found;
                r_skid_offset <= res_offset;
                r_skid_length <= res_length;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_value_offset = r_out_offset;
    assign o_value_length = r_out_length;

    // skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output entry");

    // a finished value parks the scanner until end of text
    a_done_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_phase == jkv_pkg::PH_SEARCH))
        else $error("scanner active after value completed");

    // bracket depth lives only while measuring an object or array
    a_depth_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth != '0) |-> (r_phase == jkv_pkg::PH_OBJECT || r_phase == jkv_pkg::PH_ARRAY))
        else $error("nonzero depth outside object or array");

    // end of text restarts the scan
    a_text_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_end_of_text) |=> (r_pos == '0 && !r_done))
        else $error("scan state not cleared after end of text");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for json_key_value_extractor_unit, streams json texts and
// checks found / offset / length of each result against an in-bench scan model
// depends on jkv_pkg and the json_key_value_extractor_unit rtl

module tb_top;

    localparam int STALL_LIMIT = 2000;
    localparam int WIN_LEN     = jkv_pkg::KEY_MAX_DEF + 2;
    localparam int POS_LAST    = jkv_pkg::TEXT_MAX_DEF - 1;
    localparam int LEN_SAT     = 65535;
    localparam int DEPTH_SAT   = 65535;

    localparam logic [jkv_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic                      found;
        logic [jkv_pkg::POS_W-1:0] offset;
        logic [jkv_pkg::LEN_W-1:0] length;
    } t_value_span;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [jkv_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [jkv_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [7:0]                    i_text_byte = '0;
    logic                          i_end_of_text = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic                          o_found;
    logic [jkv_pkg::POS_W-1:0]     o_value_offset;
    logic [jkv_pkg::LEN_W-1:0]     o_value_length;

    // scan model state
    logic [7:0]      win [WIN_LEN];
    int unsigned     win_fill;
    jkv_pkg::t_phase scan_state;
    int unsigned     depth;
    int unsigned     byte_pos;
    int unsigned     start_pos;
    bit              value_done;
    logic [63:0]     key_lo;
    logic [63:0]     key_hi;
    logic [4:0]      key_len;

    t_value_span     spans_due[$];
    logic [7:0]      text_buf[$];
    logic [7:0]      key_pick [16];
    int              key_used;
    int              fail_count = 0;
    int              quiet_cycles = 0;
    int              stall_left = 0;
    bit              calm = 1'b0;

    json_key_value_extractor_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_value_offset (o_value_offset),
        .o_value_length (o_value_length)
    );

    always #10 i_clk = ~i_clk;

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // ---------------- scan model ----------------

    function automatic bit is_blank(input logic [7:0] c);
        return c == jkv_pkg::CH_SPACE || c == jkv_pkg::CH_TAB || c == jkv_pkg::CH_LF ||
               c == jkv_pkg::CH_VT || c == jkv_pkg::CH_FF || c == jkv_pkg::CH_CR;
    endfunction

    function automatic bit ends_bare(input logic [7:0] c);
        return c == jkv_pkg::CH_SPACE || c == jkv_pkg::CH_LBRACE ||
               c == jkv_pkg::CH_RBRACE || c == jkv_pkg::CH_LBRACK ||
               c == jkv_pkg::CH_RBRACK || c == jkv_pkg::CH_COMMA ||
               c == jkv_pkg::CH_LF || c == jkv_pkg::CH_CR;
    endfunction

    function automatic int unsigned clamp_pos(input int unsigned p);
        return (p > POS_LAST) ? POS_LAST : p;
    endfunction

    task automatic clear_scan();
        for (int i = 0; i < WIN_LEN; i++) win[i] = '0;
        win_fill = 0;
        scan_state = jkv_pkg::PH_SEARCH;
        depth = 0;
        byte_pos = 0;
        start_pos = 0;
        value_done = 1'b0;
    endtask

    function automatic bit key_hit();
        int unsigned n;
        logic [7:0] kc;
        n = (key_len > jkv_pkg::KEY_MAX_DEF) ? jkv_pkg::KEY_MAX_DEF : key_len;
        if (win_fill < n + 2) return 1'b0;
        if (win[0] != jkv_pkg::CH_QUOTE || win[n+1] != jkv_pkg::CH_QUOTE) return 1'b0;
        for (int i = 0; i < n; i++) begin
            if (i < 8) kc = key_lo[8*i +: 8];
            else kc = key_hi[8*(i-8) +: 8];
            if (win[n-i] != kc) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic close_value(input int unsigned off, input int unsigned stop);
        t_value_span s;
        int unsigned n;
        n = (stop > off) ? stop - off : 0;
        if (n > LEN_SAT) n = LEN_SAT;
        s.found = 1'b1;
        s.offset = off[15:0];
        s.length = n[15:0];
        spans_due.push_back(s);
        value_done = 1'b1;
        scan_state = jkv_pkg::PH_SEARCH;
    endtask

    task automatic start_value(input logic [7:0] c, input int unsigned p);
        if (c == jkv_pkg::CH_LBRACE || c == jkv_pkg::CH_LBRACK) begin
            start_pos = p;
            depth = 1;
            scan_state = (c == jkv_pkg::CH_LBRACE) ? jkv_pkg::PH_OBJECT : jkv_pkg::PH_ARRAY;
        end else if (c == jkv_pkg::CH_QUOTE) begin
            start_pos = clamp_pos(p + 1);
            scan_state = jkv_pkg::PH_STRING;
        end else if (ends_bare(c)) begin
            close_value(p, p);
        end else begin
            start_pos = p;
            scan_state = jkv_pkg::PH_OTHER;
        end
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic last);
        int unsigned p;
        logic [7:0] open_c;
        logic [7:0] close_c;
        t_value_span miss;
        p = byte_pos;
        if (!value_done) begin
            case (scan_state)
                jkv_pkg::PH_SEARCH: begin
                    for (int i = WIN_LEN - 1; i > 0; i--) win[i] = win[i-1];
                    win[0] = c;
                    if (win_fill < WIN_LEN) win_fill++;
                    if (key_hit()) scan_state = jkv_pkg::PH_WS1;
                end
                jkv_pkg::PH_WS1: begin
                    if (!is_blank(c)) begin
                        if (c == jkv_pkg::CH_COLON) scan_state = jkv_pkg::PH_COLON;
                        else start_value(c, p);
                    end
                end
                jkv_pkg::PH_COLON: begin
                    if (c != jkv_pkg::CH_COLON) begin
                        if (is_blank(c)) scan_state = jkv_pkg::PH_WS2;
                        else start_value(c, p);
                    end
                end
                jkv_pkg::PH_WS2: begin
                    if (!is_blank(c)) start_value(c, p);
                end
                jkv_pkg::PH_OBJECT, jkv_pkg::PH_ARRAY: begin
                    open_c = (scan_state == jkv_pkg::PH_ARRAY) ? jkv_pkg::CH_LBRACK
                                                               : jkv_pkg::CH_LBRACE;
                    close_c = (scan_state == jkv_pkg::PH_ARRAY) ? jkv_pkg::CH_RBRACK
                                                                : jkv_pkg::CH_RBRACE;
                    if (c == close_c) begin
                        if (depth != 0) depth--;
                        if (depth == 0) close_value(start_pos, p + 1);
                    end else if (c == open_c && depth < DEPTH_SAT) begin
                        depth++;
                    end
                end
                jkv_pkg::PH_STRING: begin
                    if (c == jkv_pkg::CH_QUOTE) close_value(start_pos, p);
                end
                default: begin
                    if (ends_bare(c)) close_value(start_pos, p);
                end
            endcase
        end
        if (last) begin
            if (!value_done) begin
                miss.found = 1'b0;
                miss.offset = '0;
                miss.length = '0;
                spans_due.push_back(miss);
            end
            clear_scan();
        end else begin
            byte_pos = clamp_pos(p + 1);
        end
    endtask

    // ---------------- drivers ----------------

    always @(negedge i_clk) begin
        if (calm) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 15);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic wait_drained();
        while (spans_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [jkv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [jkv_pkg::CFG_W-1:0] data);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        if (idx == jkv_pkg::REG_KEY_LOW) key_lo = data;
        else if (idx == jkv_pkg::REG_KEY_HIGH) key_hi = data;
        else if (idx == jkv_pkg::REG_KEY_LEN) key_len = data[4:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_key(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [63:0] len_word);
        write_reg(jkv_pkg::REG_KEY_LOW, lo);
        write_reg(jkv_pkg::REG_KEY_HIGH, hi);
        write_reg(jkv_pkg::REG_KEY_LEN, len_word);
    endtask

    function automatic logic [63:0] pack_chars(input string s, input int base);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < 8; i++)
            if (base + i < s.len()) w[8*i +: 8] = s[base+i];
        return w;
    endfunction

    task automatic put(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task automatic put_byte(input logic [7:0] b);
        text_buf.push_back(b);
    endtask

    // sends text_buf as one text, end_of_text on its last byte
    task automatic send_text();
        int last_i;
        last_i = text_buf.size() - 1;
        for (int i = 0; i <= last_i; i++) begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_in_valid = 1'b0;
                if ($urandom_range(0, 31) == 0) wait_drained();
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
            i_in_valid = 1'b1;
            i_text_byte = text_buf[i];
            i_end_of_text = (i == last_i);
            do @(posedge i_clk); while (o_in_stall);
            scan_byte(text_buf[i], i == last_i);
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;
        text_buf.delete();
    endtask

    // ---------------- result check ----------------

    always @(posedge i_clk) begin : check_results
        t_value_span want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (spans_due.size() == 0) begin
                note_failure($sformatf("result with none due: found=%0b off=%0d len=%0d",
                                       o_found, o_value_offset, o_value_length));
            end else begin
                want = spans_due.pop_front();
                if (o_found !== want.found || o_value_offset !== want.offset ||
                    o_value_length !== want.length)
                    note_failure($sformatf({"mismatch: expected found=%0b off=%0d len=%0d,",
                                            " got found=%0b off=%0d len=%0d"},
                                           want.found, want.offset, want.length,
                                           o_found, o_value_offset, o_value_length));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_value_kinds();
        load_key(pack_chars("id", 0), '0, 64'd2);
        put("{\"id\":42}");              send_text();
        put("{\"id\" : \"abc\"}");        send_text();
        put("{\"id\":[1,[2],\"]\"]}");    send_text();
        put("{\"id\":");
        put_byte(jkv_pkg::CH_TAB); put_byte(jkv_pkg::CH_VT); put_byte(jkv_pkg::CH_FF);
        put("{\"a\":{}}}");              send_text();
        put("{\"x\":1}");                send_text();
        put("\"id\":5");                 send_text();
        put("\"id\"");                   send_text();
        put("\"id\"::");
        put_byte(jkv_pkg::CH_CR); put_byte(jkv_pkg::CH_LF);
        put(",");                        send_text();
        put("\"id\"}");                  send_text();
        put("\"id\":1 \"id\":2");        send_text();
        put("\"id\":7,");                send_text();
        put("\"id\":\"\"");              send_text();
        put("x");                        send_text();
        put("\"id\":12");
        put_byte(jkv_pkg::CH_TAB);
        put("3]");                       send_text();
    endtask

    task automatic test_key_extremes();
        // empty key looks for two adjacent quotes
        load_key('0, '0, 64'd0);
        put("{\"\":7}");                 send_text();
        load_key(pack_chars("abcdefghijklmnop", 0), pack_chars("abcdefghijklmnop", 8), 64'd16);
        put("{\"abcdefghijklmnop\": [1]}"); send_text();
        put("{\"abcdefghijklmno\":1}");  send_text();
        // lengths above the window size act as the full window
        write_reg(jkv_pkg::REG_KEY_LEN, {59'h7ff_ffff_ffff_ffff, 5'd31});
        put("{\"abcdefghijklmnop\":true}"); send_text();
        write_reg(jkv_pkg::REG_KEY_LEN, 64'd17);
        put("\"abcdefghijklmnop\"\"x\"");  send_text();
        write_reg(REG_UNUSED, '1);
        put("{\"abcdefghijklmnop\":{}}"); send_text();
        load_key('1, '1, 64'd16);
        put_byte(jkv_pkg::CH_QUOTE);
        repeat (16) put_byte(8'hff);
        put("\":[ ]");                   send_text();
        put_byte(jkv_pkg::CH_QUOTE);
        repeat (15) put_byte(8'hff);
        put("\":1,");                    send_text();
    endtask

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 5))
            0: return jkv_pkg::CH_SPACE;
            1: return jkv_pkg::CH_TAB;
            2: return jkv_pkg::CH_LF;
            3: return jkv_pkg::CH_VT;
            4: return jkv_pkg::CH_FF;
            default: return jkv_pkg::CH_CR;
        endcase
    endfunction

    task automatic put_nested(input logic [7:0] open_c, input logic [7:0] close_c);
        int d;
        d = 1;
        put_byte(open_c);
        repeat ($urandom_range(0, 10)) begin
            case ($urandom_range(0, 8))
                0, 1: if (d < 4) begin put_byte(open_c); d++; end
                2, 3: if (d > 1) begin put_byte(close_c); d--; end
                4: put_byte(jkv_pkg::CH_QUOTE);
                5: put_byte(jkv_pkg::CH_COLON);
                6: put_byte(jkv_pkg::CH_COMMA);
                7: put_byte((open_c == jkv_pkg::CH_LBRACE) ? jkv_pkg::CH_LBRACK
                                                           : jkv_pkg::CH_LBRACE);
                default: put_byte((open_c == jkv_pkg::CH_LBRACE) ? jkv_pkg::CH_RBRACK
                                                                 : jkv_pkg::CH_RBRACE);
            endcase
        end
        while (d > 0) begin
            put_byte(close_c);
            d--;
        end
    endtask

    task automatic put_value();
        logic [7:0] sc;
        case ($urandom_range(0, 5))
            0: begin
                repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(48, 57)));
                case ($urandom_range(0, 6))
                    0: put_byte(jkv_pkg::CH_SPACE);
                    1: put_byte(jkv_pkg::CH_CR);
                    2: put_byte(jkv_pkg::CH_LF);
                    3: put_byte(jkv_pkg::CH_TAB);
                    4: put_byte(jkv_pkg::CH_RBRACK);
                    default: ;
                endcase
            end
            1: begin
                put_byte(jkv_pkg::CH_QUOTE);
                repeat ($urandom_range(0, 8)) begin
                    sc = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(128, 255))
                                                     : 8'($urandom_range(32, 126));
                    put_byte((sc == jkv_pkg::CH_QUOTE) ? jkv_pkg::CH_COLON : sc);
                end
                put_byte(jkv_pkg::CH_QUOTE);
            end
            2: put_nested(jkv_pkg::CH_LBRACE, jkv_pkg::CH_RBRACE);
            3: put_nested(jkv_pkg::CH_LBRACK, jkv_pkg::CH_RBRACK);
            4: ;
            default: put("true");
        endcase
    endtask

    task automatic put_key();
        put_byte(jkv_pkg::CH_QUOTE);
        for (int i = 0; i < key_used; i++) put_byte(key_pick[i]);
        put_byte(jkv_pkg::CH_QUOTE);
    endtask

    task automatic build_random_text();
        int kind;
        int cut;
        int n;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 24)) put_byte(8'($urandom_range(0, 255)));
            return;
        end
        put_byte(jkv_pkg::CH_LBRACE);
        if ($urandom_range(0, 1) == 1) begin
            // decoy key sharing a prefix with the real one
            put_byte(jkv_pkg::CH_QUOTE);
            n = $urandom_range(0, key_used);
            for (int i = 0; i < n; i++) put_byte(key_pick[i]);
            if ($urandom_range(0, 1) == 1) put_byte(8'($urandom_range(97, 122)));
            put("\":1,");
        end
        put_key();
        repeat ($urandom_range(0, 2)) put_byte(random_blank());
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 1)
            put_byte(jkv_pkg::CH_COLON);
        repeat ($urandom_range(0, 2)) put_byte(random_blank());
        put_value();
        if ($urandom_range(0, 2) == 0) begin
            put_byte(jkv_pkg::CH_COMMA);
            put_key();
            put(":9");
        end
        put_byte(jkv_pkg::CH_RBRACE);
        if (kind == 1) begin
            cut = $urandom_range(1, text_buf.size());
            text_buf = text_buf[0:cut-1];
        end
    endtask

    task automatic test_random_texts();
        int texts_done;
        int bytes_done;
        int phase_bytes;
        int n;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] len_word;
        texts_done = 0;
        bytes_done = 0;
        while (bytes_done < 300 || texts_done < 16) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8);
            for (int i = 0; i < 16; i++)
                key_pick[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(97, 122));
            for (int i = 0; i < 8; i++) begin
                lo[8*i +: 8] = key_pick[i];
                hi[8*i +: 8] = key_pick[i+8];
            end
            len_word = {$urandom, $urandom};
            len_word[4:0] = n[4:0];
            key_used = (n > jkv_pkg::KEY_MAX_DEF) ? jkv_pkg::KEY_MAX_DEF : n;
            load_key(lo, hi, len_word);
            calm = ($urandom_range(0, 3) == 0);
            phase_bytes = 0;
            while (phase_bytes < 100) begin
                build_random_text();
                phase_bytes += text_buf.size();
                texts_done++;
                send_text();
            end
            bytes_done += phase_bytes;
        end
    endtask

    task automatic test_calm_tail();
        calm = 1'b1;
        repeat (8) begin
            build_random_text();
            send_text();
        end
    endtask

    initial begin
        key_lo = '0;
        key_hi = '0;
        key_len = '0;
        key_used = 0;
        clear_scan();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_value_kinds();
        test_key_extremes();
        test_random_texts();
        test_calm_tail();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (spans_due.size() != 0) note_failure("results still due at end of run");
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/jkv_pkg.sv
src/jkv_key_window.sv
src/json_key_value_extractor_unit.sv
bench/tb_top.sv
